// ===== rtl/tgrp_pkg.sv =====
// Package for the touch-gated rainbow PWM block: widths, reset values,
// register indexes and the hue phase type. No dependencies.
package tgrp_pkg;

    localparam int PWM_TOP    = 256;
    localparam int LEVEL_W    = 9;
    localparam int THR_W      = 10;
    localparam int QUIET_W    = 16;
    localparam int STEP_W     = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = LEVEL_W'(PWM_TOP);
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = THR_W'(8);
    localparam logic [QUIET_W-1:0] QUIET_LIMIT_RST = QUIET_W'(300);
    localparam logic [STEP_W-1:0]  FADE_STEP_RST  = STEP_W'(4);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_QUIET_LIMIT = 2'd1,
        CFG_FADE_STEP   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_GREEN_UP   = 3'd0,
        PH_RED_DOWN   = 3'd1,
        PH_BLUE_UP    = 3'd2,
        PH_GREEN_DOWN = 3'd3,
        PH_RED_UP     = 3'd4,
        PH_BLUE_DOWN  = 3'd5
    } hue_phase_t;

endpackage

// ===== rtl/touch_gated_rainbow_pwm.sv =====
// Touch-gated rainbow fader with software PWM for an active-low RGB LED.
// Holds the touch gate, quiet counter, PWM counter and hue machine; uses tgrp_pkg.
//
// Channel  | Direction | Contents
// s_       | in        | tuser: sample_valid; tdata: touch_sample [9:0]
// m_       | out       | tdata: red_pin, green_pin, blue_pin, lamp_enabled [3:0]
// cfg_     | in        | register write: threshold, quiet limit, fade step
//
// One item is taken per cycle while s_tready is high; its result is registered in the
// output register when it is taken, after a single pass through the compare and add logic.
// Reset is synchronous and returns all state and registers but m_tdata_reg to their defaults.
// A stalled result holds the output register, and s_tready drops only while
// that register is full and not being taken.
module touch_gated_rainbow_pwm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] sample_valid
    input  logic [tgrp_pkg::S_DATA_W-1:0]   s_tdata,   // [9:0] touch_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] red_pin, [1] green_pin, [2] blue_pin, [3] lamp_enabled
    output logic [tgrp_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [tgrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tgrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tgrp_pkg::*;

    logic [THR_W-1:0]   threshold_reg;
    logic [QUIET_W-1:0] quiet_limit_reg;
    logic [STEP_W-1:0]  fade_step_reg;

    logic [LEVEL_W-1:0] red_level_reg, red_level_next;
    logic [LEVEL_W-1:0] green_level_reg, green_level_next;
    logic [LEVEL_W-1:0] blue_level_reg, blue_level_next;
    hue_phase_t         hue_phase_reg, hue_phase_next;
    logic [LEVEL_W-1:0] pwm_count_reg, pwm_count_next;
    logic [QUIET_W-1:0] quiet_count_reg, quiet_count_next;
    logic               lamp_on_reg, lamp_on_next;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               accept;
    logic [THR_W-1:0]   sample;
    logic               touch;
    logic [QUIET_W-1:0] quiet_inc;
    logic               lamp_touched;
    logic               step_en;
    logic               red_pin, green_pin, blue_pin;

    logic [LEVEL_W-1:0] sel_level;
    logic               sel_up;
    logic               sel_known;
    logic [LEVEL_W:0]   up_sum;
    logic [LEVEL_W-1:0] moved_level;
    logic               sel_done;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign sample   = s_tdata[THR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RST;
            quiet_limit_reg <= QUIET_LIMIT_RST;
            fade_step_reg   <= FADE_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_THRESHOLD:   threshold_reg   <= cfg_wdata[THR_W-1:0];
                CFG_QUIET_LIMIT: quiet_limit_reg <= cfg_wdata[QUIET_W-1:0];
                CFG_FADE_STEP:   fade_step_reg   <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Touch gate and quiet counter.
    always_comb begin
        touch        = s_tuser && (sample > threshold_reg);
        lamp_touched = lamp_on_reg || touch;
        quiet_inc    = quiet_count_reg;
        if (s_tuser && !touch && (quiet_count_reg != {QUIET_W{1'b1}})) begin
            quiet_inc = quiet_count_reg + QUIET_W'(1);
        end
        if (quiet_inc > quiet_limit_reg) begin
            quiet_count_next = '0;
            lamp_on_next     = 1'b0;
        end else begin
            quiet_count_next = quiet_inc;
            lamp_on_next     = lamp_touched;
        end
    end

    assign step_en = lamp_on_next && (pwm_count_reg >= LEVEL_MAX);

    // Channel selection and direction for the current hue phase.
    always_comb begin
        sel_level = red_level_reg;
        sel_up    = 1'b0;
        sel_known = 1'b1;
        unique case (hue_phase_reg)
            PH_GREEN_UP:   begin sel_level = green_level_reg; sel_up = 1'b1; end
            PH_RED_DOWN:   begin sel_level = red_level_reg;   sel_up = 1'b0; end
            PH_BLUE_UP:    begin sel_level = blue_level_reg;  sel_up = 1'b1; end
            PH_GREEN_DOWN: begin sel_level = green_level_reg; sel_up = 1'b0; end
            PH_RED_UP:     begin sel_level = red_level_reg;   sel_up = 1'b1; end
            PH_BLUE_DOWN:  begin sel_level = blue_level_reg;  sel_up = 1'b0; end
            default:       sel_known = 1'b0;
        endcase
    end

    always_comb begin
        up_sum = {1'b0, sel_level} + (LEVEL_W + 1)'(fade_step_reg);
        if (sel_up) begin
            moved_level = (up_sum >= (LEVEL_W + 1)'(PWM_TOP)) ? LEVEL_MAX
                                                                : up_sum[LEVEL_W-1:0];
            sel_done    = (up_sum >= (LEVEL_W + 1)'(PWM_TOP));
        end else begin
            moved_level = (sel_level > LEVEL_W'(fade_step_reg))
                        ? sel_level - LEVEL_W'(fade_step_reg) : '0;
            sel_done    = (moved_level == '0);
        end
    end

    // Next hue phase.
    always_comb begin
        hue_phase_next = hue_phase_reg;
        if (step_en) begin
            if (!sel_known) begin
                hue_phase_next = PH_GREEN_UP;
            end else if (sel_done) begin
                unique case (hue_phase_reg)
                    PH_GREEN_UP:   hue_phase_next = PH_RED_DOWN;
                    PH_RED_DOWN:   hue_phase_next = PH_BLUE_UP;
                    PH_BLUE_UP:    hue_phase_next = PH_GREEN_DOWN;
                    PH_GREEN_DOWN: hue_phase_next = PH_RED_UP;
                    PH_RED_UP:     hue_phase_next = PH_BLUE_DOWN;
                    PH_BLUE_DOWN:  hue_phase_next = PH_GREEN_UP;
                    default:       hue_phase_next = PH_GREEN_UP;
                endcase
            end
        end
    end

    // Channel levels, PWM counter and pins.
    always_comb begin
        red_level_next   = red_level_reg;
        green_level_next = green_level_reg;
        blue_level_next  = blue_level_reg;
        pwm_count_next   = pwm_count_reg;
        red_pin          = 1'b0;
        green_pin        = 1'b0;
        blue_pin         = 1'b0;
        if (lamp_on_next) begin
            red_pin   = !(pwm_count_reg < red_level_reg);
            green_pin = !(pwm_count_reg < green_level_reg);
            blue_pin  = !(pwm_count_reg < blue_level_reg);
            if (step_en) begin
                pwm_count_next = '0;
                case (hue_phase_reg)
                    PH_GREEN_UP, PH_GREEN_DOWN: green_level_next = moved_level;
                    PH_RED_DOWN, PH_RED_UP:     red_level_next   = moved_level;
                    PH_BLUE_UP, PH_BLUE_DOWN:   blue_level_next  = moved_level;
                    default: ;
                endcase
            end else begin
                pwm_count_next = pwm_count_reg + LEVEL_W'(1);
            end
        end
        m_tdata_next = {{(M_DATA_W - 4){1'b0}}, lamp_on_next, blue_pin, green_pin, red_pin};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_level_reg   <= LEVEL_MAX;
            green_level_reg <= '0;
            blue_level_reg  <= '0;
            hue_phase_reg   <= PH_GREEN_UP;
            pwm_count_reg   <= '0;
            quiet_count_reg <= '0;
            lamp_on_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                red_level_reg   <= red_level_next;
                green_level_reg <= green_level_next;
                blue_level_reg  <= blue_level_next;
                hue_phase_reg   <= hue_phase_next;
                pwm_count_reg   <= pwm_count_next;
                quiet_count_reg <= quiet_count_next;
                lamp_on_reg     <= lamp_on_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_levels_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (red_level_reg <= LEVEL_MAX) && (green_level_reg <= LEVEL_MAX)
        && (blue_level_reg <= LEVEL_MAX) && (pwm_count_reg <= LEVEL_MAX))
        else $error("level or PWM count above period top");

    a_off_pins_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[3]) |-> (m_tdata_reg[2:0] == 3'b000))
        else $error("pins driven high while lamp is off");

    a_off_pwm_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !lamp_on_next) |=> $stable(pwm_count_reg) && $stable(hue_phase_reg))
        else $error("PWM count or hue moved while lamp is off");

    a_lamp_matches_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_tdata_reg[3] == lamp_on_reg))
        else $error("lamp flag in result disagrees with lamp state");

endmodule
